@@ rtl/core/bcpe_pkg.sv @@
package bcpe_pkg;

    // Degree of the curve, from 1 to 5.
    localparam int CURVE_DEGREE = 5;
    localparam int NUM_PTS      = CURVE_DEGREE + 1;

    // Configuration register file: one packed point per register.
    localparam int NUM_CFG_REGS = 6;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;

    // Fixed-point widths.
    localparam int T_W     = 17;              // t and powers, Q1.16
    localparam int PQ_W    = 2 * T_W;         // product of two powers
    localparam int BIN_W   = 4;               // binomial coefficients up to 10
    localparam int WS_W    = PQ_W + BIN_W;    // scaled weight before rounding
    localparam int W_W     = 18;              // rounded weight, Q.16
    localparam int COORD_W = 32;              // coordinate, Q16.16
    localparam int PROD_W  = COORD_W + W_W + 1;
    localparam int ACC_W   = 54;              // sum of all weighted coordinates
    localparam int FRAC_W  = 16;

    localparam logic [T_W-1:0] ONE_Q16  = T_W'(65536);
    localparam logic [T_W-1:0] HALF_Q16 = T_W'(32768);

    // Register indexes of the first control point.
    localparam logic [CFG_IDX_W-1:0] REG_POINT0 = 3'd0;

    // Pipeline depth from the accepting edge to the sampling edge of the result.
    localparam int PIPE_LAT = CURVE_DEGREE + 6;

    // Binomial coefficients, row n holds binom(n, 0..n).
    localparam int BINOM_TAB [6][6] = '{
        '{1, 0,  0,  0, 0, 0},
        '{1, 1,  0,  0, 0, 0},
        '{1, 2,  1,  0, 0, 0},
        '{1, 3,  3,  1, 0, 0},
        '{1, 4,  6,  4, 1, 0},
        '{1, 5, 10, 10, 5, 1}
    };

    // Weights of all control points, with the valid bit of their item.
    typedef struct packed {
        logic                          valid;
        logic [NUM_PTS-1:0][W_W-1:0]   weight;
    } t_weight_bus;

    // One step of a power chain: (p * t + 0.5) >> 16, both in Q1.16.
    function automatic logic [T_W-1:0] pow_step(input logic [T_W-1:0] p,
                                                input logic [T_W-1:0] t);
        logic [PQ_W-1:0] prod;
        prod = PQ_W'(p) * PQ_W'(t) + PQ_W'(HALF_Q16);
        return prod[FRAC_W +: T_W];
    endfunction

endpackage

@@ rtl/core/bcpe_weight_pipe.sv @@
module bcpe_weight_pipe
    import bcpe_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [T_W-1:0]  i_param_t,
    output t_weight_bus     o_wt
);

    localparam int NUM_STG = CURVE_DEGREE;

    logic                 r_v [NUM_STG];
    logic [T_W-1:0]       r_t [NUM_STG];
    logic [T_W-1:0]       r_u [NUM_STG];
    logic [T_W-1:0]       r_p [NUM_STG][NUM_PTS];
    logic [T_W-1:0]       r_q [NUM_STG][NUM_PTS];

    logic                 r_pq_v;
    logic [PQ_W-1:0]      r_pq [NUM_PTS];
    logic                 r_w_v;
    logic [W_W-1:0]       r_w [NUM_PTS];

    logic [T_W-1:0]       n_t;

    // Values above one are clamped to one.
    assign n_t = i_param_t[T_W-1] ? ONE_Q16 : i_param_t;

    // First stage: the zeroth and first powers of t and of 1 - t.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t[0] <= n_t;
        r_u[0] <= ONE_Q16 - n_t;
        for (int i = 0; i < NUM_PTS; i++) begin
            if (i == 0) begin
                r_p[0][i] <= ONE_Q16;
                r_q[0][i] <= ONE_Q16;
            end else if (i == 1) begin
                r_p[0][i] <= n_t;
                r_q[0][i] <= ONE_Q16 - n_t;
            end else begin
                r_p[0][i] <= '0;
                r_q[0][i] <= '0;
            end
        end
    end

    // Power chain: stage s adds the power s + 1 of both t and 1 - t.
    for (genvar s = 1; s < NUM_STG; s++) begin : g_pow
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else begin
                r_v[s] <= r_v[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_t[s] <= r_t[s-1];
            r_u[s] <= r_u[s-1];
            for (int i = 0; i < NUM_PTS; i++) begin
                if (i == s + 1) begin
                    r_p[s][i] <= pow_step(r_p[s-1][s], r_t[s-1]);
                    r_q[s][i] <= pow_step(r_q[s-1][s], r_u[s-1]);
                end else begin
                    r_p[s][i] <= r_p[s-1][i];
                    r_q[s][i] <= r_q[s-1][i];
                end
            end
        end
    end

    // Cross products of matching powers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pq_v <= 1'b0;
            r_w_v  <= 1'b0;
        end else begin
            r_pq_v <= r_v[NUM_STG-1];
            r_w_v  <= r_pq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_PTS; i++) begin
            r_pq[i] <= PQ_W'(r_p[NUM_STG-1][i]) * PQ_W'(r_q[NUM_STG-1][CURVE_DEGREE-i]);
        end
    end

    // Scale by the binomial coefficient and round to Q.16.
    always_ff @(posedge i_clk) begin
        logic [WS_W-1:0] scaled;
        for (int i = 0; i < NUM_PTS; i++) begin
            scaled = WS_W'(r_pq[i]) * WS_W'(BINOM_TAB[CURVE_DEGREE][i])
                   + WS_W'(HALF_Q16);
            r_w[i] <= scaled[FRAC_W +: W_W];
        end
    end

    always_comb begin
        o_wt.valid = r_w_v;
        for (int i = 0; i < NUM_PTS; i++) begin
            o_wt.weight[i] = r_w[i];
        end
    end

endmodule

@@ rtl/core/bezier_curve_point_evaluator_core.sv @@
// Path: an accepted item passes through the weight pipeline, then the product,
// pair-sum, sum and output registers, whose valid bit drives the strobe.
// Throughput: one item per cycle; busy is low except during reset, and the
// receiver cannot stall, so results leave in the order items came in.
// Reset: synchronous, active low; clears all valid bits and the control points.
module bezier_curve_point_evaluator_core
    import bcpe_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [T_W-1:0]              i_param_t,
    output logic                        o_busy,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    output logic                        o_strobe,
    output logic signed [COORD_W-1:0]   o_point_x,
    output logic signed [COORD_W-1:0]   o_point_y
);

    localparam int NUM_PAIRS = (NUM_PTS + 1) / 2;

    t_weight_bus                    wt;
    logic                           accept;

    logic [CFG_DATA_W-1:0]          r_point [NUM_CFG_REGS];

    logic                           r_prod_v;
    logic signed [PROD_W-1:0]       r_prod_x [NUM_PTS];
    logic signed [PROD_W-1:0]       r_prod_y [NUM_PTS];
    logic                           r_part_v;
    logic signed [ACC_W-1:0]        r_part_x [NUM_PAIRS];
    logic signed [ACC_W-1:0]        r_part_y [NUM_PAIRS];
    logic                           r_sum_v;
    logic signed [ACC_W-1:0]        r_sum_x;
    logic signed [ACC_W-1:0]        r_sum_y;
    logic                           r_out_v;
    logic signed [COORD_W-1:0]      r_out_x;
    logic signed [COORD_W-1:0]      r_out_y;

    logic signed [ACC_W-1:0]        n_sum_x;
    logic signed [ACC_W-1:0]        n_sum_y;

    assign o_busy = !i_rst_n;
    assign accept = i_start && !o_busy;

    // Round half up to Q16.16, then clamp to the 32-bit range.
    function automatic logic signed [COORD_W-1:0] round_sat(input logic signed [ACC_W-1:0] s);
        logic signed [ACC_W-1:0] v;
        v = (s + $signed(ACC_W'(HALF_Q16))) >>> FRAC_W;
        if (!v[ACC_W-1] && (|v[ACC_W-2:COORD_W-1])) begin
            return {1'b0, {(COORD_W-1){1'b1}}};
        end else if (v[ACC_W-1] && !(&v[ACC_W-2:COORD_W-1])) begin
            return {1'b1, {(COORD_W-1){1'b0}}};
        end
        return v[COORD_W-1:0];
    endfunction

    // Control point registers; writes beyond the last point are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CFG_REGS; i++) begin
                r_point[i] <= '0;
            end
        end else if (i_cfg_we) begin
            for (int i = 0; i < NUM_CFG_REGS; i++) begin
                if (i_cfg_index == REG_POINT0 + CFG_IDX_W'(i)) begin
                    r_point[i] <= i_cfg_data;
                end
            end
        end
    end

    // Bernstein weights for the parameter value.
    bcpe_weight_pipe u_weight (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (accept),
        .i_param_t (i_param_t),
        .o_wt      (wt)
    );

    // Valid bits of the accumulate stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_v <= 1'b0;
            r_part_v <= 1'b0;
            r_sum_v  <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_prod_v <= wt.valid;
            r_part_v <= r_prod_v;
            r_sum_v  <= r_part_v;
            r_out_v  <= r_sum_v;
        end
    end

    // Weighted coordinates, one multiplier per coordinate.
    always_ff @(posedge i_clk) begin
        logic signed [W_W:0] w_s;
        for (int i = 0; i < NUM_PTS; i++) begin
            w_s = $signed({1'b0, wt.weight[i]});
            r_prod_x[i] <= $signed(r_point[i][CFG_DATA_W-1 -: COORD_W]) * w_s;
            r_prod_y[i] <= $signed(r_point[i][COORD_W-1:0]) * w_s;
        end
    end

    // First level of the adder tree: pairs of products.
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < NUM_PAIRS; j++) begin
            if (2 * j + 1 < NUM_PTS) begin
                r_part_x[j] <= ACC_W'(r_prod_x[2*j]) + ACC_W'(r_prod_x[2*j+1]);
                r_part_y[j] <= ACC_W'(r_prod_y[2*j]) + ACC_W'(r_prod_y[2*j+1]);
            end else begin
                r_part_x[j] <= ACC_W'(r_prod_x[2*j]);
                r_part_y[j] <= ACC_W'(r_prod_y[2*j]);
            end
        end
    end

    // Second level: the remaining few partial sums.
    always_comb begin
        n_sum_x = '0;
        n_sum_y = '0;
        for (int j = 0; j < NUM_PAIRS; j++) begin
            n_sum_x = n_sum_x + r_part_x[j];
            n_sum_y = n_sum_y + r_part_y[j];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum_x <= n_sum_x;
        r_sum_y <= n_sum_y;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        r_out_x <= round_sat(r_sum_x);
        r_out_y <= round_sat(r_sum_y);
    end

    assign o_strobe  = r_out_v;
    assign o_point_x = r_out_x;
    assign o_point_y = r_out_y;

    // Every result comes from an item accepted a fixed number of cycles earlier.
    a_result_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, PIPE_LAT))
        else $error("result strobe without an accepted item");

    // A finished weight set always turns into a result through the product, pair-sum, sum and output registers.
    a_weight_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wt.valid |-> ##4 o_strobe)
        else $error("weights did not produce a result");

    // No result leaves right after reset.
    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("result strobe right after reset");

endmodule

@@ bench/tb_bezier_curve_point_evaluator_core.sv @@
`timescale 1ns / 1ps

module tb_bezier_curve_point_evaluator_core;
    import bcpe_pkg::T_W;
    import bcpe_pkg::CFG_IDX_W;
    import bcpe_pkg::CFG_DATA_W;
    import bcpe_pkg::COORD_W;

    // Number of control-point registers that the block really holds.
    localparam int NUM_POINT_REGS = 6;
    // Highest index the index port can carry.
    localparam int MAX_CFG_INDEX  = (1 << CFG_IDX_W) - 1;
    // Curve degree as the block is built; eval_curve clamps it to 1..5.
    localparam int DEGREE_RAW     = bcpe_pkg::CURVE_DEGREE;
    // Extra edges that wait_drained waits once no result is owed any more.
    localparam int DRAIN_CYCLES   = 24;
    localparam int CYCLE_LIMIT    = 400000;
    localparam longint ONE_T      = 65536;
    localparam int MAX_T          = (1 << T_W) - 1;

    // Coordinate kinds used when loading random curves.
    typedef enum int {
        COORD_FULL    = 0,
        COORD_SMALL   = 1,
        COORD_EXTREME = 2,
        COORD_MIXED   = 3
    } coord_kind_t;

    typedef struct {
        logic [T_W-1:0]            t;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } curve_point_t;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_start;
    logic [T_W-1:0]              i_param_t;
    logic                        o_busy;
    logic                        i_cfg_we;
    logic [CFG_IDX_W-1:0]        i_cfg_index;
    logic [CFG_DATA_W-1:0]       i_cfg_data;
    logic                        o_strobe;
    logic signed [COORD_W-1:0]   o_point_x;
    logic signed [COORD_W-1:0]   o_point_y;

    // Copy of the control points as the block should hold them.
    logic [CFG_DATA_W-1:0] ctrl_pts [NUM_POINT_REGS];
    // Curve points still owed by the block, oldest first.
    curve_point_t          pending_points [$];
    int                    err_count   = 0;
    int                    cycle_count = 0;

    bezier_curve_point_evaluator_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_param_t   (i_param_t),
        .o_busy      (o_busy),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_strobe    (o_strobe),
        .o_point_x   (o_point_x),
        .o_point_y   (o_point_y)
    );

    // Clock with a 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Bernstein-form point of the current curve at t, in fixed point.
    function automatic curve_point_t eval_curve(input logic [T_W-1:0] t_raw);
        int                        deg;
        longint unsigned           t;
        longint unsigned           u;
        longint unsigned           coef;
        longint unsigned           w;
        longint unsigned           pw [NUM_POINT_REGS];
        longint unsigned           qw [NUM_POINT_REGS];
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        longint                    sx;
        longint                    sy;
        curve_point_t              res;
        deg = DEGREE_RAW;
        if (deg < 1) deg = 1;
        if (deg > 5) deg = 5;
        t = longint'(t_raw);
        if (t > ONE_T) t = ONE_T;
        u = ONE_T - t;
        pw[0] = ONE_T;
        qw[0] = ONE_T;
        for (int i = 1; i <= deg; i++) begin
            pw[i] = (pw[i-1] * t + 32768) >> 16;
            qw[i] = (qw[i-1] * u + 32768) >> 16;
        end
        // Accumulate weighted coordinates; coef walks along the binomial row.
        sx = 0;
        sy = 0;
        coef = 1;
        for (int i = 0; i <= deg; i++) begin
            w  = (coef * pw[i] * qw[deg-i] + 32768) >> 16;
            cx = ctrl_pts[i][63:32];
            cy = ctrl_pts[i][31:0];
            sx += longint'(cx) * longint'(w);
            sy += longint'(cy) * longint'(w);
            coef = coef * longint'(deg - i) / longint'(i + 1);
        end
        // Round half up, then saturate to 32 bits.
        sx = (sx + 32768) >>> 16;
        sy = (sy + 32768) >>> 16;
        if (sx > 64'sd2147483647) sx = 64'sd2147483647;
        if (sx < -64'sd2147483648) sx = -64'sd2147483648;
        if (sy > 64'sd2147483647) sy = 64'sd2147483647;
        if (sy < -64'sd2147483648) sy = -64'sd2147483648;
        res.t = t_raw;
        res.x = sx[31:0];
        res.y = sy[31:0];
        return res;
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_count++;
    endtask

    // Present one item and hold it until the block takes it.
    task automatic send_param(input logic [T_W-1:0] t);
        bit taken;
        taken = 1'b0;
        @(negedge i_clk);
        i_start   <= 1'b1;
        i_param_t <= t;
        while (!taken) begin
            @(posedge i_clk);
            taken = !o_busy;
        end
        pending_points.push_back(eval_curve(t));
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            i_start <= 1'b0;
        end
    endtask

    // Stop sending and let every owed result come out.
    task automatic wait_drained();
        idle_cycles(1);
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Register writes; the caller ends a run of them with end_writes.
    task automatic write_point(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        if (idx < NUM_POINT_REGS) ctrl_pts[idx] = data;
    endtask

    task automatic end_writes();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [COORD_W-1:0] rand_coord(input coord_kind_t kind);
        logic [COORD_W-1:0] v;
        case (kind)
            COORD_SMALL: begin
                v = COORD_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
            end
            COORD_EXTREME: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'hFFFF_FFFF;
                    default: v = 32'h0000_0000;
                endcase
            end
            default: begin
                v = $urandom;
            end
        endcase
        return v;
    endfunction

    // Load a whole random curve, sometimes followed by stray writes.
    task automatic load_curve(input coord_kind_t kind);
        coord_kind_t k;
        wait_drained();
        for (int i = 0; i < NUM_POINT_REGS; i++) begin
            k = kind;
            if (kind == COORD_MIXED) k = coord_kind_t'($urandom_range(0, 2));
            write_point(CFG_IDX_W'(i), {rand_coord(k), rand_coord(k)});
        end
        if ($urandom_range(0, 3) == 0) begin
            write_point(CFG_IDX_W'($urandom_range(NUM_POINT_REGS, MAX_CFG_INDEX)),
                        {$urandom, $urandom});
        end
        end_writes();
    endtask

    // Mostly t in range, some exact ends, some above one.
    function automatic logic [T_W-1:0] rand_param();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0) return T_W'(0);
        if (sel == 1) return T_W'(ONE_T);
        if (sel < 4) return T_W'($urandom_range(ONE_T + 1, MAX_T));
        return T_W'($urandom_range(0, ONE_T));
    endfunction

    // Compare each result with the oldest owed point.
    always @(posedge i_clk) begin : check_results
        curve_point_t want;
        if (i_rst_n && o_strobe) begin
            if (pending_points.size() == 0) begin
                report_error($sformatf("result with nothing owed: x=%h y=%h",
                                       o_point_x, o_point_y));
            end else begin
                want = pending_points.pop_front();
                if (o_point_x !== want.x) begin
                    report_error($sformatf("point_x at t=%0d: got %h, want %h",
                                           want.t, o_point_x, want.x));
                end
                if (o_point_y !== want.y) begin
                    report_error($sformatf("point_y at t=%0d: got %h, want %h",
                                           want.t, o_point_y, want.y));
                end
            end
        end
    end

    // Hard stop if the run hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Right after reset every point is zero, so the whole curve is the origin.
    task automatic test_reset_points();
        send_param(T_W'(0));
        send_param(T_W'(ONE_T));
        send_param(T_W'(MAX_T));
        send_param(T_W'(12345));
    endtask

    // Hand-picked curves and parameter values, including the saturating ones.
    task automatic test_directed();
        wait_drained();
        write_point(CFG_IDX_W'(0), {32'h0000_0000, 32'h0000_0000});
        write_point(CFG_IDX_W'(1), {32'h0001_0000, 32'h0002_0000});
        write_point(CFG_IDX_W'(2), {32'hFFFD_0000, 32'h0004_8000});
        write_point(CFG_IDX_W'(3), {32'h0005_0000, 32'hFFFA_0000});
        write_point(CFG_IDX_W'(4), {32'h0010_4000, 32'h0000_0001});
        write_point(CFG_IDX_W'(5), {32'h7000_0000, 32'h9000_0000});
        end_writes();
        // Ends of the range, values above one that must clamp, and values inside the range.
        send_param(T_W'(0));
        send_param(T_W'(ONE_T));
        send_param(T_W'(ONE_T + 1));
        send_param(T_W'(MAX_T));
        send_param(T_W'(32768));
        send_param(T_W'(1));
        send_param(T_W'(ONE_T - 1));
        send_param(T_W'(16384));

        // Every x at the top and every y at the bottom of the range.
        wait_drained();
        for (int i = 0; i < NUM_POINT_REGS; i++) begin
            write_point(CFG_IDX_W'(i), {32'h7FFF_FFFF, 32'h8000_0000});
        end
        end_writes();
        send_param(T_W'(0));
        send_param(T_W'(21845));
        send_param(T_W'(32768));
        send_param(T_W'(ONE_T));

        // Alternating extremes and an all-ones word.
        wait_drained();
        for (int i = 0; i < NUM_POINT_REGS; i++) begin
            write_point(CFG_IDX_W'(i), (i % 2 == 0) ? {32'h8000_0000, 32'h7FFF_FFFF}
                                                    : {32'hFFFF_FFFF, 32'hFFFF_FFFF});
        end
        end_writes();
        send_param(T_W'(10923));
        send_param(T_W'(49152));

        // Writes past the last point must not change the curve.
        wait_drained();
        write_point(CFG_IDX_W'(6), {32'h1234_5678, 32'h9ABC_DEF0});
        write_point(CFG_IDX_W'(7), {32'hFFFF_FFFF, 32'hFFFF_FFFF});
        end_writes();
        send_param(T_W'(40000));
        send_param(T_W'(ONE_T));
    endtask

    // Random curves, each hit by a stream of t with random gaps.
    task automatic test_random_curves();
        for (int phase = 0; phase < 14; phase++) begin
            load_curve(coord_kind_t'(phase % 4));
            for (int n = 0; n < 110; n++) begin
                if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 13));
                send_param(rand_param());
            end
        end
    endtask

    // Back-to-back items with no gaps at all.
    task automatic test_streaming();
        load_curve(COORD_MIXED);
        for (int n = 0; n < 200; n++) send_param(rand_param());
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_param_t   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        for (int i = 0; i < NUM_POINT_REGS; i++) ctrl_pts[i] = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_points();
        test_directed();
        test_random_curves();
        test_streaming();

        wait_drained();
        if (pending_points.size() != 0) begin
            report_error($sformatf("%0d results never came", pending_points.size()));
        end
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
